>>> rtl/fsfa_pkg.sv
// Shared types and constants of the free-segment fit allocator.
// Used by every module of the block; has no dependencies of its own.
package fsfa_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int ADDR_W          = 32;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2,
      ST_ZERO  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2,
      POL_SPARE = 2'd3
   } policy_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      REG_FIT_POLICY = 1'b0,
      REG_NONE       = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_EDIT
   } state_type;

   // One free segment as held in a cell of the table.
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] len;
   } seg_type;

endpackage

>>> rtl/fsfa_cell.sv
// One cell of the segment table chain: holds a single segment.
// Depends on fsfa_pkg for the segment type.
module fsfa_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  fsfa_pkg::seg_type seg_in,
   output fsfa_pkg::seg_type seg_out
);
   import fsfa_pkg::*;

   seg_type seg_ff;

   // Payload only, so no reset is needed.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_out = seg_ff;

endmodule

>>> rtl/free_segment_fit_allocator.sv
// Free-segment table allocator built as a ring of ENTRIES cells.
// A zero size, or a free that runs past the top of the address space, is answered from idle;
// other requests take a search turn of the ring, a decide step and, unless refused, an edit turn.
// Only one request is taken at a time: a new one is accepted only while idle.
// Reset (synchronous, active high) empties the table, clears the next-fit history and
// selects first fit. Results are strobed for one cycle and the receiver cannot stall.
module free_segment_fit_allocator #(
   parameter int ENTRIES = fsfa_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [fsfa_pkg::ADDR_W-1:0]   req_seg_addr,
   input  logic [fsfa_pkg::ADDR_W-1:0]   req_seg_size,
   // result channel
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [fsfa_pkg::ADDR_W-1:0]   rsp_result_addr,
   output logic [$clog2(ENTRIES+1)-1:0]  rsp_free_count,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import fsfa_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(ENTRIES - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   // Everything the search turn learns about the table.
   typedef struct packed {
      logic          hit_a;   // first entry large enough
      logic [IW-1:0] idx_a;
      logic          hit_b;   // first large enough above the last allocation
      logic [IW-1:0] idx_b;
      logic          hit_e;   // first exact match
      logic [IW-1:0] idx_e;
      logic          hit_l;   // smallest larger entry
      logic [IW-1:0] idx_l;
      logic [ADDR_W-1:0] len_l;
      logic [CW-1:0] pos;     // entries that start below the freed address
      seg_type       prev;
      logic          next_hit;
      seg_type       next;
   } scan_type;

   // The edit that the second turn applies.
   typedef struct packed {
      logic          op_alloc;
      logic          op_set;
      logic          op_del;
      logic          op_ins;
      logic [CW-1:0] set_idx;
      logic [CW-1:0] del_idx;
      seg_type       mod;
   } edit_type;

   state_type state_ff, state_in;
   logic [IW-1:0] t_ff, t_in;
   logic [CW-1:0] used_ff, used_in;
   logic [1:0]    policy_ff, policy_in;
   logic          lav_ff, lav_in;
   logic [ADDR_W-1:0] lad_ff, lad_in;
   logic          is_free_ff, is_free_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, size_ff, size_in;
   scan_type      scan_ff, scan_in;
   edit_type      edit_ff, edit_in;
   logic          del_act_ff, del_act_in;
   seg_type       prev_head_ff, prev_head_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   seg_type       cell_q [ENTRIES];
   seg_type       feed, head, nxt;
   logic          shift_en;

   // ------------------------------------------------------------------
   // The cell ring. Every cell passes its segment one place towards the
   // head in each step; the head's segment, possibly edited, re-enters at
   // the tail. After a full turn the value fed at step t sits in cell t,
   // so each turn rewrites the table in order.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == ENTRIES - 1) begin : g_tail
         fsfa_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .seg_in   (feed),
            .seg_out  (cell_q[g])
         );
      end else begin : g_body
         fsfa_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .seg_in   (cell_q[g+1]),
            .seg_out  (cell_q[g])
         );
      end
   end

   assign head     = cell_q[0];
   assign nxt      = cell_q[1];
   assign shift_en = (state_ff == S_SEARCH) || (state_ff == S_EDIT);

   // ------------------------------------------------------------------
   // Configuration port. The only register is the fit policy at byte
   // address zero; a write to the next word is ignored.
   // ------------------------------------------------------------------
   logic cfg_write;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_FIT_POLICY) ? {30'd0, policy_ff} : 32'd0;
   assign policy_in = (cfg_write && paddr[2] == REG_FIT_POLICY) ? pwdata[1:0] : policy_ff;

   // ------------------------------------------------------------------
   // Decision arithmetic for a free, evaluated in the decide cycle from
   // the neighbours captured during the search turn. Sums are widened by
   // one bit (the three-way sum by two) so that a merge whose length would not fit is seen.
   // ------------------------------------------------------------------
   logic [ADDR_W:0]   prev_end, prev_sum, next_sum, free_end;
   logic [ADDR_W+1:0] three_sum;
   logic              dup, mp, mn, m3;

   assign prev_end  = {1'b0, scan_ff.prev.start} + {1'b0, scan_ff.prev.len};
   assign prev_sum  = {1'b0, scan_ff.prev.len} + {1'b0, size_ff};
   assign next_sum  = {1'b0, scan_ff.next.len} + {1'b0, size_ff};
   assign free_end  = {1'b0, addr_ff} + {1'b0, size_ff};
   assign three_sum = {1'b0, prev_sum} + {2'b00, scan_ff.next.len};

   assign dup = scan_ff.next_hit && (scan_ff.next.start == addr_ff);
   assign mp  = (scan_ff.pos != '0) && (prev_end == {1'b0, addr_ff}) && !prev_sum[ADDR_W];
   assign mn  = scan_ff.next_hit && (free_end == {1'b0, scan_ff.next.start})
                && !next_sum[ADDR_W];
   assign m3  = mp && mn && (three_sum[ADDR_W+1:ADDR_W] == 2'b00);

   // Request checks made on acceptance.
   logic [ADDR_W:0] req_end;
   logic            past_top;
   assign req_end  = {1'b0, req_seg_addr} + {1'b0, req_seg_size};
   assign past_top = req_end[ADDR_W] && (req_end[ADDR_W-1:0] != '0);

   logic entry_valid;
   logic at_set, at_del, del_start, last_step;
   assign entry_valid = CW'(t_ff) < used_ff;
   assign at_set      = CW'(t_ff) == edit_ff.set_idx;
   assign at_del      = CW'(t_ff) == edit_ff.del_idx;
   assign last_step   = t_ff == LAST_STEP;

   always_comb begin
      state_in      = state_ff;
      t_in          = t_ff;
      used_in       = used_ff;
      lav_in        = lav_ff;
      lad_in        = lad_ff;
      is_free_in    = is_free_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      scan_in       = scan_ff;
      edit_in       = edit_ff;
      del_act_in    = del_act_ff;
      prev_head_in  = prev_head_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      feed          = head;
      del_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               is_free_in = req_type;
               addr_in    = req_seg_addr;
               size_in    = req_seg_size;
               t_in       = '0;
               scan_in    = '0;
               if (req_seg_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_ZERO;
                  rsp_addr_in   = '0;
                  rsp_count_in  = used_ff;
               end else if (req_type == REQ_FREE && past_top) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOFIT;
                  rsp_addr_in   = '0;
                  rsp_count_in  = used_ff;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            // Pure rotation; watch each held segment as it passes the head.
            if (entry_valid) begin
               if (!scan_ff.hit_a && head.len >= size_ff) begin
                  scan_in.hit_a = 1'b1;
                  scan_in.idx_a = t_ff;
               end
               if (!scan_ff.hit_b && head.start > lad_ff && head.len >= size_ff) begin
                  scan_in.hit_b = 1'b1;
                  scan_in.idx_b = t_ff;
               end
               if (!scan_ff.hit_e && head.len == size_ff) begin
                  scan_in.hit_e = 1'b1;
                  scan_in.idx_e = t_ff;
               end
               if (head.len > size_ff && (!scan_ff.hit_l || head.len < scan_ff.len_l)) begin
                  scan_in.hit_l = 1'b1;
                  scan_in.idx_l = t_ff;
                  scan_in.len_l = head.len;
               end
               if (head.start < addr_ff) begin
                  scan_in.prev = head;
                  scan_in.pos  = CW'(t_ff) + CW'(1);
               end else if (!scan_ff.next_hit) begin
                  scan_in.next_hit = 1'b1;
                  scan_in.next     = head;
               end
            end
            t_in = t_ff + IW'(1);
            if (last_step) begin
               t_in     = '0;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            edit_in      = '0;
            del_act_in   = 1'b0;
            rsp_addr_in  = '0;
            rsp_count_in = used_ff;
            if (is_free_ff == REQ_ALLOC) begin
               logic          found;
               logic [IW-1:0] pick;
               found = scan_ff.hit_a;
               pick  = scan_ff.idx_a;
               case (policy_ff)
                  POL_BEST: begin
                     found = scan_ff.hit_e || scan_ff.hit_l;
                     pick  = scan_ff.hit_e ? scan_ff.idx_e : scan_ff.idx_l;
                  end
                  POL_NEXT: begin
                     if (lav_ff && scan_ff.hit_b) begin
                        pick = scan_ff.idx_b;
                     end
                  end
                  default: begin
                  end
               endcase
               if (found) begin
                  edit_in.op_alloc = 1'b1;
                  edit_in.set_idx  = CW'(pick);
                  state_in         = S_EDIT;
               end else begin
                  lav_in        = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOFIT;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_EDIT;
               if (dup) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOFIT;
                  state_in      = S_IDLE;
               end else if (m3) begin
                  // Both neighbours touch: grow the lower one, drop the upper one.
                  edit_in.op_set  = 1'b1;
                  edit_in.op_del  = 1'b1;
                  edit_in.set_idx = scan_ff.pos - CW'(1);
                  edit_in.del_idx = scan_ff.pos;
                  edit_in.mod     = '{start: scan_ff.prev.start, len: three_sum[ADDR_W-1:0]};
               end else if (mp) begin
                  edit_in.op_set  = 1'b1;
                  edit_in.set_idx = scan_ff.pos - CW'(1);
                  edit_in.mod     = '{start: scan_ff.prev.start, len: prev_sum[ADDR_W-1:0]};
               end else if (mn) begin
                  edit_in.op_set  = 1'b1;
                  edit_in.set_idx = scan_ff.pos;
                  edit_in.mod     = '{start: addr_ff, len: next_sum[ADDR_W-1:0]};
               end else if (used_ff >= FULL_COUNT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  edit_in.op_ins  = 1'b1;
                  edit_in.del_idx = scan_ff.pos;
                  edit_in.mod     = '{start: addr_ff, len: size_ff};
               end
            end
         end

         S_EDIT: begin
            // Second turn: feed back each segment with the edit applied.
            // A removal feeds the following segment from then on, an
            // insertion feeds the one seen a step earlier.
            if (del_act_ff) begin
               feed = nxt;
            end else if (edit_ff.op_ins && CW'(t_ff) > edit_ff.del_idx) begin
               feed = prev_head_ff;
            end
            if (edit_ff.op_ins && at_del) begin
               feed = edit_ff.mod;
            end
            if (edit_ff.op_set && at_set) begin
               feed = edit_ff.mod;
            end
            if (edit_ff.op_del && at_del) begin
               feed      = nxt;
               del_start = 1'b1;
            end
            if (edit_ff.op_alloc && at_set) begin
               res_addr_in = head.start;
               if (head.len == size_ff) begin
                  feed      = nxt;
                  del_start = 1'b1;
               end else begin
                  feed = '{start: head.start + size_ff, len: head.len - size_ff};
               end
            end
            del_act_in   = del_act_ff || del_start;
            prev_head_in = head;
            t_in         = t_ff + IW'(1);
            if (last_step) begin
               t_in     = '0;
               state_in = S_IDLE;
               if (del_act_ff || del_start) begin
                  used_in = used_ff - CW'(1);
               end else if (edit_ff.op_ins) begin
                  used_in = used_ff + CW'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = used_in;
               rsp_addr_in   = '0;
               if (edit_ff.op_alloc) begin
                  rsp_addr_in = at_set ? head.start : res_addr_ff;
                  lav_in      = 1'b1;
                  lad_in      = rsp_addr_in;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         t_ff         <= '0;
         used_ff      <= '0;
         policy_ff    <= POL_FIRST;
         lav_ff       <= 1'b0;
         lad_ff       <= '0;
         del_act_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         used_ff      <= used_in;
         policy_ff    <= policy_in;
         lav_ff       <= lav_in;
         lad_ff       <= lad_in;
         del_act_ff   <= del_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      scan_ff       <= scan_in;
      edit_ff       <= edit_in;
      prev_head_ff  <= prev_head_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_free_count  = rsp_count_ff;

endmodule
